@@ hdl/psa_pkg.sv @@
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, codes and helpers for the slot allocator with handles.
// ----------------------------------------------------------------------------
package psa_pkg;

    // Request codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_CHECK  = 2'd3;

    // Force codes; any other code acts as hard force
    localparam logic [1:0] FORCE_NONE = 2'd0;
    localparam logic [1:0] FORCE_SOFT = 2'd1;

    // Handle layout: generation above an 8-bit index field
    localparam int IDX_BITS = 8;
    localparam int GEN_W    = 24;
    localparam int HANDLE_W = 32;
    localparam int ORDER_W  = 32;

    // Classified request, passed from the front end to the engine
    typedef struct packed {
        logic [1:0]          op;
        logic [7:0]          prio;
        logic                evict;       // eviction allowed when full
        logic                lower_only;  // evict only a strictly lower priority
        logic                add_ok;      // payload reference is non-zero
        logic                hvalid;      // handle non-zero and index in range
        logic [HANDLE_W-1:0] handle;
    } t_req;

    // One slot record as held in RAM
    typedef struct packed {
        logic [7:0]         prio;
        logic [ORDER_W-1:0] order;
        logic [GEN_W-1:0]   gen;
    } t_slot;

    // Advance a generation, wrapping past zero
    function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = g + GEN_W'(1);
        return (n == '0) ? GEN_W'(1) : n;
    endfunction

endpackage

@@ hdl/psa_ram.sv @@
// ----------------------------------------------------------------------------
// psa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module psa_ram #(
    parameter int W = 64,
    parameter int D = 8,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/psa_front.sv @@
// ----------------------------------------------------------------------------
// psa_front
// Request intake: classify each request and hold it in a two-entry queue.
// ----------------------------------------------------------------------------
module psa_front
    import psa_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_req_type,
    input  logic [7:0]          i_new_priority,
    input  logic [1:0]          i_force_mode,
    input  logic [7:0]          i_payload_id,
    input  logic [HANDLE_W-1:0] i_handle_in,
    output logic                o_q_empty,
    input  logic                i_q_pop,
    output t_req                o_q_head
);

    t_req       w_cls;
    t_req       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;

    // Classify the incoming request
    always_comb begin
        w_cls            = '0;
        w_cls.op         = i_req_type;
        w_cls.prio       = i_new_priority;
        w_cls.evict      = (i_force_mode != FORCE_NONE);
        w_cls.lower_only = (i_force_mode == FORCE_SOFT);
        w_cls.add_ok     = (i_payload_id != 8'd0);
        w_cls.hvalid     = (i_handle_in != '0) &&
                           (i_handle_in[IDX_BITS-1:0] < IDX_BITS'(SLOTS));
        w_cls.handle     = i_handle_in;
    end

    assign full      = (r_cnt == 2'd2);
    assign o_q_empty = (r_cnt == 2'd0);
    assign o_q_head  = r_q[r_rd];
    assign w_push    = push && !full;
    assign w_pop     = i_q_pop && !o_q_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // Store the classified transaction
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cls;
        end
    end

endmodule

@@ hdl/psa_back.sv @@
// ----------------------------------------------------------------------------
// psa_back
// Execution engine: slot scan, victim choice, handle match, clear sweep,
// and the single-entry result register.
// ----------------------------------------------------------------------------
module psa_back
    import psa_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  t_req                i_q_head,
    output logic                empty,
    input  logic                pop,
    output logic                o_status,
    output logic [HANDLE_W-1:0] o_handle_out
);

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int SW   = $bits(t_slot);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_READ   = 6'b001000,
        S_MATCH  = 6'b010000,
        S_SWEEP  = 6'b100000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_req                r_req;
    logic [CW-1:0]       r_idx;
    logic                r_pv;
    logic [IW-1:0]       r_pidx;
    logic [IW-1:0]       r_rd_addr;
    logic                r_free_ok;
    logic [IW-1:0]       r_free_idx;
    logic [GEN_W-1:0]    r_free_gen;
    logic                r_vic_ok;
    logic [IW-1:0]       r_vic_idx;
    logic [7:0]          r_vic_prio;
    logic [ORDER_W-1:0]  r_vic_order;
    logic [GEN_W-1:0]    r_vic_gen;
    logic [SLOTS-1:0]    r_busy;
    logic [SLOTS-1:0]    r_valid;
    logic [ORDER_W-1:0]  r_order;
    logic                r_res_valid;
    logic                r_res_status;
    logic [HANDLE_W-1:0] r_res_handle;

    logic                w_start;
    logic                w_issue;
    logic                w_last;
    logic [IW-1:0]       w_hidx;
    logic [IW-1:0]       w_raddr;
    logic [SW-1:0]       w_rdata;
    t_slot               w_word;
    logic                w_we;
    logic [IW-1:0]       w_waddr;
    t_slot               w_wdata;
    logic                w_take;
    logic [IW-1:0]       w_tidx;
    logic [GEN_W-1:0]    w_tgen;
    logic [GEN_W-1:0]    w_newgen;
    logic                w_hit;
    logic                w_better;

    psa_ram #(
        .W (SW),
        .D (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_start = (r_state == S_IDLE) && !i_q_empty && !r_res_valid;
    assign o_q_pop = w_start;
    assign w_hidx  = r_req.handle[IW-1:0];
    assign w_issue = (r_idx < CW'(SLOTS));
    assign w_last  = r_pv && (r_pidx == IW'(SLOTS - 1));

    // Entries never written read as the reset record
    assign w_word  = r_valid[r_rd_addr] ? t_slot'(w_rdata) : '0;

    // Read address: scan counter, or the handle index
    always_comb begin
        w_raddr = '0;
        if (r_state == S_READ) begin
            w_raddr = w_hidx;
        end else if ((r_state == S_SCAN || r_state == S_SWEEP) && w_issue) begin
            w_raddr = r_idx[IW-1:0];
        end
    end

    // Victim comparison: lower priority, then older stamp
    assign w_better = !r_vic_ok || (w_word.prio < r_vic_prio) ||
                      ((w_word.prio == r_vic_prio) && (w_word.order < r_vic_order));

    // Target choice for an add
    always_comb begin
        w_take = 1'b0;
        w_tidx = r_free_idx;
        w_tgen = r_free_gen;
        if (r_free_ok) begin
            w_take = 1'b1;
        end else if (r_req.evict && r_vic_ok) begin
            w_tidx = r_vic_idx;
            w_tgen = r_vic_gen;
            w_take = !(r_req.lower_only && (r_vic_prio >= r_req.prio));
        end
    end
    assign w_newgen = bump_gen(w_tgen);

    assign w_hit = r_busy[w_hidx] && (w_word.gen == r_req.handle[HANDLE_W-1:IDX_BITS]);

    // Slot RAM writes: new entry on add, bumped generation on sweep
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pidx;
        w_wdata = w_word;
        if (r_state == S_DECIDE) begin
            w_we          = w_take;
            w_waddr       = w_tidx;
            w_wdata.prio  = r_req.prio;
            w_wdata.order = r_order;
            w_wdata.gen   = w_newgen;
        end else if (r_state == S_SWEEP) begin
            w_we        = r_pv;
            w_wdata.gen = bump_gen(w_word.gen);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    case (i_q_head.op)
                        OP_ADD:    n_state = i_q_head.add_ok ? S_SCAN : S_IDLE;
                        OP_CLEAR:  n_state = S_SWEEP;
                        default:   n_state = i_q_head.hvalid ? S_READ : S_IDLE;
                    endcase
                end
            end
            S_SCAN:   n_state = w_last ? S_DECIDE : S_SCAN;
            S_DECIDE: n_state = S_IDLE;
            S_READ:   n_state = S_MATCH;
            S_MATCH:  n_state = S_IDLE;
            S_SWEEP:  n_state = w_last ? S_IDLE : S_SWEEP;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state, slot flags and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_valid     <= '0;
            r_order     <= '0;
            r_res_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_pv  <= 1'b0;
                    if (w_start) begin
                        case (i_q_head.op)
                            OP_ADD: begin
                                if (!i_q_head.add_ok) begin
                                    r_res_valid <= 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                r_busy <= '0;
                            end
                            default: begin
                                if (!i_q_head.hvalid) begin
                                    r_res_valid <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN, S_SWEEP: begin
                    if (w_issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    r_pv <= w_issue && !w_last;
                    if (r_state == S_SWEEP) begin
                        if (r_pv) begin
                            r_valid[r_pidx] <= 1'b1;
                        end
                        if (w_last) begin
                            r_res_valid <= 1'b1;
                        end
                    end
                end
                S_DECIDE: begin
                    r_res_valid <= 1'b1;
                    if (w_take) begin
                        r_busy[w_tidx]  <= 1'b1;
                        r_valid[w_tidx] <= 1'b1;
                        r_order         <= r_order + ORDER_W'(1);
                    end
                end
                S_MATCH: begin
                    r_res_valid <= 1'b1;
                    if (w_hit && (r_req.op == OP_REMOVE)) begin
                        r_busy[w_hidx] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Request latch, scan bookkeeping and result payload
    always_ff @(posedge i_clk) begin
        r_rd_addr <= w_raddr;
        r_pidx    <= r_idx[IW-1:0];
        if (w_start) begin
            r_req        <= i_q_head;
            r_free_ok    <= 1'b0;
            r_vic_ok     <= 1'b0;
            r_res_status <= (i_q_head.op != OP_CLEAR);
            r_res_handle <= '0;
        end
        // Track the first free slot and the eviction candidate
        if (r_state == S_SCAN && r_pv) begin
            if (!r_busy[r_pidx] && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_pidx;
                r_free_gen <= w_word.gen;
            end
            if (r_busy[r_pidx] && w_better) begin
                r_vic_ok    <= 1'b1;
                r_vic_idx   <= r_pidx;
                r_vic_prio  <= w_word.prio;
                r_vic_order <= w_word.order;
                r_vic_gen   <= w_word.gen;
            end
        end
        if (r_state == S_DECIDE && w_take) begin
            r_res_status <= 1'b0;
            r_res_handle <= {w_newgen, IDX_BITS'(w_tidx)};
        end
        if (r_state == S_MATCH) begin
            r_res_status <= !w_hit;
        end
    end

    assign empty        = !r_res_valid;
    assign o_status     = r_res_status;
    assign o_handle_out = r_res_handle;

    // The engine only works while the result register is free
    a_idle_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_state == S_IDLE))
        else $error("engine busy while a result is held");

    // The order stamp moves only when an add takes a slot
    a_order_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_order != $past(r_order)) |-> ($past(r_state) == S_DECIDE))
        else $error("order stamp advanced outside an add");

    // RAM writes happen only when placing an entry or sweeping
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_DECIDE || r_state == S_SWEEP))
        else $error("slot RAM written in a wrong phase");

    // A finished clear leaves every slot free
    a_clear_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SWEEP) && w_last) |=> (r_busy == '0))
        else $error("slot still busy after clear");

endmodule

@@ hdl/priority_slot_allocator_with_handles_unit.sv @@
// ----------------------------------------------------------------------------
// priority_slot_allocator_with_handles_unit
// Slot pool with generation-checked handles and priority eviction.
//
//   channel   handshake      payload
//   request   push / full    i_req_type, i_new_priority, i_force_mode,
//                            i_payload_id, i_handle_in
//   result    empty / pop    o_status, o_handle_out
//
// Add scans every slot through the slot RAM, one read a cycle. Remove and
// check read the handle's slot; clear runs a generation sweep through the
// RAM, and a refused request is answered without touching the RAM.
// Reset is synchronous; no clearing pass, unwritten slots read as zero.
// A two-entry request queue takes transactions while a result waits in
// the one-entry result register; the engine holds until that is popped.
// ----------------------------------------------------------------------------
module priority_slot_allocator_with_handles_unit
    import psa_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_req_type,
    input  logic [7:0]          i_new_priority,
    input  logic [1:0]          i_force_mode,
    input  logic [7:0]          i_payload_id,
    input  logic [HANDLE_W-1:0] i_handle_in,
    output logic                empty,
    input  logic                pop,
    output logic                o_status,
    output logic [HANDLE_W-1:0] o_handle_out
);

    logic w_q_empty;
    logic w_q_pop;
    t_req w_q_head;

    // Intake and classification
    psa_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_new_priority (i_new_priority),
        .i_force_mode   (i_force_mode),
        .i_payload_id   (i_payload_id),
        .i_handle_in    (i_handle_in),
        .o_q_empty      (w_q_empty),
        .i_q_pop        (w_q_pop),
        .o_q_head       (w_q_head)
    );

    // Execution and result
    psa_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .o_q_pop      (w_q_pop),
        .i_q_head     (w_q_head),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_handle_out (o_handle_out)
    );

endmodule
